[rtl/core/ndt_pkg.sv]
// shared constants, result codes and control structs for the name dedup table
package ndt_pkg;

    localparam int MAX_NAMES_DEF = 64;
    localparam int MAX_LEN_DEF   = 128;

    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int UCOUNT_W = 7;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW  = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic    take_char;
        logic    entry_clr;
        logic    entry_next;
        logic    idx_next;
        logic    copy_wr;
        logic    finish;
        status_t fin_status;
    } dp_cmd_t;

    typedef struct packed {
        logic j_at_count;
        logic full;
        logic len_eq;
        logic byte_eq;
        logic idx_last;
        logic out_free;
    } dp_stat_t;

endpackage

[rtl/core/ndt_char_if.sv]
// character input channel
interface ndt_char_if import ndt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
    logic              first_name;

    modport source (output valid, output char_code, output last_char, output first_name,
                    input ready);
    modport sink (input valid, input char_code, input last_char, input first_name,
                  output ready);
endinterface

[rtl/core/ndt_result_if.sv]
// result output channel
interface ndt_result_if import ndt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [UCOUNT_W-1:0] unique_count;

    modport source (output valid, output status, output slot, output unique_count,
                    input ready);
    modport sink (input valid, input status, input slot, input unique_count,
                  output ready);
endinterface

[rtl/core/ndt_datapath.sv]
// name buffer, table memories, search counters and result register
module ndt_datapath import ndt_pkg::*; #(
    parameter int MAX_NAMES = MAX_NAMES_DEF,
    parameter int MAX_LEN   = MAX_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              first_name,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    ndt_result_if.source      result_out
);

    localparam int NW = $clog2(MAX_NAMES);
    localparam int CW = $clog2(MAX_NAMES + 1);
    localparam int IW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);

    logic [LW-1:0] cur_len_reg, cur_len_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic          out_valid_reg, out_valid_next;

    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [UCOUNT_W-1:0] out_ucount_reg;

    logic [CHAR_W-1:0] cur_mem [MAX_LEN];
    logic [CHAR_W-1:0] store_mem [MAX_NAMES][MAX_LEN];
    logic [LW-1:0]     len_mem [MAX_NAMES];

    logic [CHAR_W-1:0] cur_rd_reg;
    logic [CHAR_W-1:0] store_rd_reg;
    logic [LW-1:0]     len_rd_reg;

    logic        room;
    logic        commit_new;
    logic [31:0] slot_wide;
    logic [31:0] ucount_wide;

    assign room       = cur_len_reg < LW'(MAX_LEN);
    assign commit_new = cmd.finish && (cmd.fin_status == ST_NEW);

    always_comb
    begin
        cur_len_next = cur_len_reg;
        if (cmd.finish)
        begin
            cur_len_next = '0;
        end
        else if (cmd.take_char && room)
        begin
            cur_len_next = cur_len_reg + LW'(1);
        end

        count_next = count_reg;
        if (cmd.take_char && first_name)
        begin
            count_next = '0;
        end
        else if (commit_new)
        begin
            count_next = count_reg + CW'(1);
        end

        j_next = j_reg;
        k_next = k_reg;
        if (cmd.entry_clr)
        begin
            j_next = '0;
            k_next = '0;
        end
        else if (cmd.entry_next)
        begin
            j_next = j_reg + CW'(1);
            k_next = '0;
        end
        else if (cmd.idx_next)
        begin
            k_next = k_reg + IW'(1);
        end

        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        case (cmd.fin_status)
            ST_NEW:
            begin
                slot_wide   = 32'(count_reg);
                ucount_wide = 32'(count_reg) + 32'd1;
            end
            ST_DUP:
            begin
                slot_wide   = 32'(j_reg);
                ucount_wide = 32'(count_reg);
            end
            default:
            begin
                slot_wide   = '0;
                ucount_wide = 32'(count_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_len_reg   <= '0;
            count_reg     <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_len_reg   <= cur_len_next;
            count_reg     <= count_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_status_reg <= cmd.fin_status;
            out_slot_reg   <= slot_wide[SLOT_W-1:0];
            out_ucount_reg <= ucount_wide[UCOUNT_W-1:0];
        end
    end

    // name buffer, table rows and lengths; one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.take_char && room)
        begin
            cur_mem[cur_len_reg[IW-1:0]] <= char_code;
        end
        if (cmd.copy_wr)
        begin
            store_mem[count_reg[NW-1:0]][k_reg] <= cur_rd_reg;
        end
        if (commit_new)
        begin
            len_mem[count_reg[NW-1:0]] <= cur_len_reg;
        end
        cur_rd_reg   <= cur_mem[k_reg];
        store_rd_reg <= store_mem[j_reg[NW-1:0]][k_reg];
        len_rd_reg   <= len_mem[j_reg[NW-1:0]];
    end

    assign stat.j_at_count = (j_reg == count_reg);
    assign stat.full       = (count_reg == CW'(MAX_NAMES));
    assign stat.len_eq     = (len_rd_reg == cur_len_reg);
    assign stat.byte_eq    = (store_rd_reg == cur_rd_reg);
    assign stat.idx_last   = ((LW'(k_reg) + LW'(1)) == cur_len_reg);
    assign stat.out_free   = !out_valid_reg || result_out.ready;

    assign result_out.valid        = out_valid_reg;
    assign result_out.status       = out_status_reg;
    assign result_out.slot         = out_slot_reg;
    assign result_out.unique_count = out_ucount_reg;

endmodule

[rtl/core/ndt_ctrl.sv]
// sequencer for character intake, table search, row copy and result hand-off
module ndt_ctrl import ndt_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_last,
    input  dp_stat_t stat,
    output logic     in_ready,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN_WAIT,
        S_LEN_CHK,
        S_BYTE_WAIT,
        S_BYTE_CHK,
        S_COPY_WAIT,
        S_COPY_WR,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    status_t fin_reg, fin_next;
    logic    fire;

    assign in_ready = (state_reg == S_IDLE);
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        fin_next       = fin_reg;
        cmd            = '0;
        cmd.fin_status = fin_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take_char = fire;
                if (fire && in_last)
                begin
                    cmd.entry_clr = 1'b1;
                    state_next    = S_LEN_WAIT;
                end
            end
            S_LEN_WAIT:
            begin
                if (stat.j_at_count)
                begin
                    if (stat.full)
                    begin
                        fin_next   = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_COPY_WAIT;
                    end
                end
                else
                begin
                    state_next = S_LEN_CHK;
                end
            end
            S_LEN_CHK:
            begin
                if (stat.len_eq)
                begin
                    state_next = S_BYTE_WAIT;
                end
                else
                begin
                    cmd.entry_next = 1'b1;
                    state_next     = S_LEN_WAIT;
                end
            end
            S_BYTE_WAIT:
            begin
                state_next = S_BYTE_CHK;
            end
            S_BYTE_CHK:
            begin
                if (!stat.byte_eq)
                begin
                    cmd.entry_next = 1'b1;
                    state_next     = S_LEN_WAIT;
                end
                else if (stat.idx_last)
                begin
                    fin_next   = ST_DUP;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.idx_next = 1'b1;
                    state_next   = S_BYTE_WAIT;
                end
            end
            S_COPY_WAIT:
            begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                cmd.copy_wr = 1'b1;
                if (stat.idx_last)
                begin
                    fin_next   = ST_NEW;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.idx_next = 1'b1;
                    state_next   = S_COPY_WAIT;
                end
            end
            S_DONE:
            begin
                // hold the result until the output word register frees up
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= ST_NEW;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

[rtl/core/name_dedup_table_top.sv]
// Order-preserving duplicate name filter.
// char_in takes one character word per cycle; last_char ends a name and
// first_name (on any character of a name) empties the table first.
// result_out gives one word per finished name: status new, duplicate or
// full, the slot stored or matched, and the unique count after the name.
// Characters past MAX_LEN are dropped; names compare over length and bytes.
// A character that does not end a name is simply stored. An ending character
// starts the search, which walks the stored rows one at a time through one
// read port per memory: a row whose length differs is left after its length
// check, a row of equal length is compared byte by byte, and the search
// ends on a full match or at the end of the table. A new name is then
// copied into its row byte by byte, and then the result register is loaded.
// char_in stays low-ready from the ending character until that load.
// While result_out is stalled, characters of the next name are still taken;
// the next result waits until the held word is taken.
// Reset empties the table and the name buffer at once; no clearing pass.
module name_dedup_table_top import ndt_pkg::*; #(
    parameter int MAX_NAMES = MAX_NAMES_DEF,
    parameter int MAX_LEN   = MAX_LEN_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ndt_char_if.sink     char_in,
    ndt_result_if.source result_out
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ndt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (char_in.valid),
        .in_last  (char_in.last_char),
        .stat     (stat),
        .in_ready (char_in.ready),
        .cmd      (cmd)
    );

    ndt_datapath #(
        .MAX_NAMES (MAX_NAMES),
        .MAX_LEN   (MAX_LEN)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_code  (char_in.char_code),
        .first_name (char_in.first_name),
        .cmd        (cmd),
        .stat       (stat),
        .result_out (result_out)
    );

endmodule
